// ===== design/swm_pkg.sv =====
`timescale 1ns / 1ps

package swm_pkg;

  // Width of the window size register and of the reported fill count.
  localparam int WIN_W = 5;

  // Window size after reset.
  localparam logic [WIN_W-1:0] WIN_RESET = 5'd16;

  // Control that the top level broadcasts to every cell of the sorted chain.
  typedef struct packed {
    logic load;   // a new sample enters the chain at this edge
    logic clear;  // the history is dropped at this edge
    logic full;   // the window is full, so the oldest sample leaves
  } cell_ctl_t;

endpackage

// ===== design/swm_in_if.sv =====
`timescale 1ns / 1ps

interface swm_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/swm_out_if.sv =====
`timescale 1ns / 1ps

interface swm_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_BITS:0]  median_x2;
  logic [swm_pkg::WIN_W-1:0]    window_fill;

  modport source (output valid, output median_x2, output window_fill, input ready);
  modport sink   (input valid, input median_x2, input window_fill, output ready);
endinterface

// ===== design/swm_cell.sv =====
`timescale 1ns / 1ps

// One place of the sorted window. It holds a sample and its age and rebuilds
// them from its own state, its two neighbors or the new sample as one enters.
module swm_cell #(
  parameter int W     = 16,
  parameter int AGE_W = 4,
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  swm_pkg::cell_ctl_t  ctl,
  input  logic signed [W-1:0] sample,
  input  logic [AGE_W-1:0]    oldest_age,
  input  logic [IDX_W-1:0]    lo_idx,
  input  logic [IDX_W-1:0]    hi_idx,
  // Stored contents of the right neighbor.
  input  logic signed [W-1:0] right_val,
  input  logic [AGE_W-1:0]    right_age,
  input  logic                right_vld,
  // Contents of the left neighbor once the leaving sample is squeezed out.
  input  logic signed [W-1:0] left_cval,
  input  logic [AGE_W-1:0]    left_cage,
  input  logic                left_cvld,
  input  logic                left_gt,
  input  logic                rem_in,
  output logic                rem_out,
  output logic signed [W-1:0] cval,
  output logic [AGE_W-1:0]    cage,
  output logic                cvld,
  output logic                gt,
  output logic signed [W-1:0] val,
  output logic [AGE_W-1:0]    age,
  output logic                vld,
  input  logic [W-1:0]        lo_in,
  input  logic [W-1:0]        hi_in,
  output logic [W-1:0]        lo_out,
  output logic [W-1:0]        hi_out
);

  logic                leaving;
  logic signed [W-1:0] val_next;
  logic [AGE_W-1:0]    age_next;
  logic                vld_next;

  assign leaving = ctl.full && vld && (age == oldest_age);
  assign rem_out = rem_in | leaving;

  // Once the leaving sample lies at or left of this place, the list shifts left.
  assign cval = rem_out ? right_val : val;
  assign cage = rem_out ? right_age : age;
  assign cvld = rem_out ? right_vld : vld;

  // Empty places sort above every sample, so a new sample lands at the end.
  assign gt = !cvld || (cval > sample);

  always_comb begin
    if (!gt) begin
      val_next = cval;
      age_next = cage + AGE_W'(1);
      vld_next = cvld;
    end else if (left_gt) begin
      val_next = left_cval;
      age_next = left_cage + AGE_W'(1);
      vld_next = left_cvld;
    end else begin
      val_next = sample;
      age_next = '0;
      vld_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      vld <= 1'b0;
    end else if (ctl.load) begin
      vld <= vld_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val <= val_next;
      age <= age_next;
    end
  end

  // The two middle samples are picked out as they pass along the chain.
  assign lo_out = lo_in | ((lo_idx == IDX_W'(IDX)) ? val : '0);
  assign hi_out = hi_in | ((hi_idx == IDX_W'(IDX)) ? val : '0);

endmodule

// ===== design/sliding_window_median_top.sv =====
`timescale 1ns / 1ps

// Running median filter over the last window_size signed samples. Every
// accepted sample transaction yields one result transaction carrying twice the
// median of the samples held so far (one fractional bit, so the mean of the two
// middle samples of an even count is exact) and the number of samples used.
// Samples are kept in a chain of MAX_WINDOW cells that stays sorted: when a
// sample enters, the oldest one leaves once the window is full, and every cell
// takes its new contents from itself, a neighbor or the new sample in the same
// clock. One sample is accepted per clock cycle; its result moves from the cells
// into an output register. While a result waits in that register one
// more sample is accepted, and after that the input stalls until the waiting
// result is taken. The clock period is set by the ripple of the removal flag
// through the cell chain followed by one compare of SAMPLE_BITS bits in each
// cell. Writing window_size, and reset, empty the window; a written value of 0
// acts as 1 and a value above MAX_WINDOW acts as MAX_WINDOW. Writes are meant
// for idle times only.
module sliding_window_median_top #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [swm_pkg::WIN_W-1:0]  cfg_wdata,
  swm_in_if.sink                     sample_ch,
  swm_out_if.source                  median_ch
);

  localparam int W      = SAMPLE_BITS;
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IDX_W  = AGE_W;
  localparam int CMP_W  = (FILL_W > swm_pkg::WIN_W) ? FILL_W : swm_pkg::WIN_W;

  // Configuration register and the window size it stands for.
  logic [swm_pkg::WIN_W-1:0] window_size;
  logic [CMP_W-1:0]          size_wide;
  logic [FILL_W-1:0]         eff_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swm_pkg::WIN_RESET;
    end else if (cfg_we) begin
      window_size <= cfg_wdata;
    end
  end

  assign size_wide = CMP_W'(window_size);

  always_comb begin
    if (size_wide == '0) begin
      eff_size = FILL_W'(1);
    end else if (size_wide > CMP_W'(MAX_WINDOW)) begin
      eff_size = FILL_W'(MAX_WINDOW);
    end else begin
      eff_size = FILL_W'(size_wide);
    end
  end

  // Handshake. The cells always hold the window of the newest accepted sample;
  // sel_valid says its median has not yet moved to the output register.
  logic sel_valid;
  logic accept;
  logic advance;

  assign advance         = sel_valid && (!median_ch.valid || median_ch.ready);
  assign sample_ch.ready = !sel_valid || advance;
  assign accept          = sample_ch.valid && sample_ch.ready;

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      sel_valid <= 1'b0;
    end else if (accept) begin
      sel_valid <= 1'b1;
    end else if (advance) begin
      sel_valid <= 1'b0;
    end
  end

  // Fill count of the window, saturating at the window size.
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              full;

  assign full      = (fill == eff_size);
  assign fill_next = full ? fill : fill + FILL_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      fill <= '0;
    end else if (accept) begin
      fill <= fill_next;
    end
  end

  // Broadcast to the cells.
  swm_pkg::cell_ctl_t ctl;
  logic [AGE_W-1:0]   oldest_age;
  logic [IDX_W-1:0]   lo_idx;
  logic [IDX_W-1:0]   hi_idx;
  logic [FILL_W-1:0]  fill_less;

  assign ctl.load   = accept;
  assign ctl.clear  = cfg_we;
  assign ctl.full   = full;
  assign oldest_age = AGE_W'(eff_size - FILL_W'(1));

  // The middle places of the sorted window; for an odd count both are the same.
  assign fill_less = fill - FILL_W'(1);
  assign lo_idx    = IDX_W'(fill_less >> 1);
  assign hi_idx    = IDX_W'(fill >> 1);

  // Chain links. Index k of the compacted and pick chains is the value handed
  // into cell k from its left; index k of the stored state is cell k itself.
  logic signed [W-1:0] st_val [MAX_WINDOW+1];
  logic [AGE_W-1:0]    st_age [MAX_WINDOW+1];
  logic [MAX_WINDOW:0] st_vld;
  logic signed [W-1:0] c_val  [MAX_WINDOW+1];
  logic [AGE_W-1:0]    c_age  [MAX_WINDOW+1];
  logic [MAX_WINDOW:0] c_vld;
  logic [MAX_WINDOW:0] c_gt;
  logic [MAX_WINDOW:0] rem;
  logic [W-1:0]        lo_chain [MAX_WINDOW+1];
  logic [W-1:0]        hi_chain [MAX_WINDOW+1];

  // Past the last cell the chain reads as empty; before the first, nothing
  // sorts above the new sample and nothing has left yet.
  assign st_val[MAX_WINDOW] = '0;
  assign st_age[MAX_WINDOW] = '0;
  assign st_vld[MAX_WINDOW] = 1'b0;
  assign c_val[0]           = '0;
  assign c_age[0]           = '0;
  assign c_vld[0]           = 1'b0;
  assign c_gt[0]            = 1'b0;
  assign rem[0]             = 1'b0;
  assign lo_chain[0]        = '0;
  assign hi_chain[0]        = '0;

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    swm_cell #(
      .W     (W),
      .AGE_W (AGE_W),
      .IDX_W (IDX_W),
      .IDX   (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sample     (sample_ch.sample),
      .oldest_age (oldest_age),
      .lo_idx     (lo_idx),
      .hi_idx     (hi_idx),
      .right_val  (st_val[k+1]),
      .right_age  (st_age[k+1]),
      .right_vld  (st_vld[k+1]),
      .left_cval  (c_val[k]),
      .left_cage  (c_age[k]),
      .left_cvld  (c_vld[k]),
      .left_gt    (c_gt[k]),
      .rem_in     (rem[k]),
      .rem_out    (rem[k+1]),
      .cval       (c_val[k+1]),
      .cage       (c_age[k+1]),
      .cvld       (c_vld[k+1]),
      .gt         (c_gt[k+1]),
      .val        (st_val[k]),
      .age        (st_age[k]),
      .vld        (st_vld[k]),
      .lo_in      (lo_chain[k]),
      .hi_in      (hi_chain[k]),
      .lo_out     (lo_chain[k+1]),
      .hi_out     (hi_chain[k+1])
    );
  end

  // Output register: sum of the two middle samples, which is twice the median.
  logic signed [W:0] lo_ext;
  logic signed [W:0] hi_ext;

  assign lo_ext = {lo_chain[MAX_WINDOW][W-1], lo_chain[MAX_WINDOW]};
  assign hi_ext = {hi_chain[MAX_WINDOW][W-1], hi_chain[MAX_WINDOW]};

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      median_ch.valid <= 1'b0;
    end else if (advance) begin
      median_ch.valid <= 1'b1;
    end else if (median_ch.ready) begin
      median_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      median_ch.median_x2   <= lo_ext + hi_ext;
      median_ch.window_fill <= swm_pkg::WIN_W'(fill);
    end
  end

  // The occupied cells always match the fill count.
  a_fill_matches_cells : assert property (@(posedge clk) disable iff (rst)
    $countones(st_vld[MAX_WINDOW-1:0]) == int'(fill))
    else $error("occupied cells differ from fill count");

  // The fill count never runs past the window size.
  a_fill_bounded : assert property (@(posedge clk) disable iff (rst)
    fill <= eff_size)
    else $error("fill count above window size");

  // With a full window, a new sample always finds the oldest one to drop.
  a_oldest_found : assert property (@(posedge clk) disable iff (rst)
    (accept && full) |-> rem[MAX_WINDOW])
    else $error("oldest sample not found in full window");

  // An accepted sample leaves its median pending in the next cycle.
  a_accept_pending : assert property (@(posedge clk) disable iff (rst)
    (accept && !cfg_we) |=> sel_valid)
    else $error("accepted transaction lost its median");

endmodule
